/* sv/bts_pkg.sv */
// Shared types, codes and tune ROM for the buzzer tune sequencer.
package bts_pkg;

  localparam int unsigned NoteIdxW = 3;
  localparam int unsigned FreqW    = 10;
  localparam int unsigned DurW     = 10;

  // func codes
  localparam logic [1:0] FuncStart = 2'd0;
  localparam logic [1:0] FuncLink  = 2'd1;
  localparam logic [1:0] FuncTimer = 2'd2;

  // reply codes
  localparam logic [1:0] ReplyWait   = 2'd0;
  localparam logic [1:0] ReplyNever  = 2'd1;
  localparam logic [1:0] ReplyIgnore = 2'd2;

  // link state codes
  localparam logic [2:0] LinkConnected    = 3'd0;
  localparam logic [2:0] LinkDisconnected = 3'd1;
  localparam logic [2:0] LinkRadioFailed  = 3'd2;
  localparam logic [2:0] LinkNoModule     = 3'd3;
  localparam logic [2:0] LinkNoneSeen     = 3'd7;

  typedef enum logic [1:0] {
    TuneStartup  = 2'd0,
    TuneFailed   = 2'd1,
    TuneNoModule = 2'd2,
    TuneLink     = 2'd3
  } tune_e;

  typedef struct packed {
    logic [FreqW-1:0] hz;
    logic [DurW-1:0]  ms;
  } note_t;

  typedef struct packed {
    logic [1:0]       reply;
    logic [DurW-1:0]  wait_ms;
    logic             tone_on;
    logic [FreqW-1:0] tone_hz;
    logic [DurW-1:0]  tone_ms;
    logic             pin_drive;
  } result_t;

  function automatic logic [NoteIdxW-1:0] tune_len(input tune_e t);
    logic [NoteIdxW-1:0] len;
    case (t)
      TuneStartup:  len = NoteIdxW'(6);
      TuneFailed:   len = NoteIdxW'(2);
      TuneNoModule: len = NoteIdxW'(2);
      default:      len = NoteIdxW'(3);
    endcase
    return len;
  endfunction

  function automatic note_t mk_note(input int unsigned hz, input int unsigned ms);
    note_t n;
    n.hz = FreqW'(hz);
    n.ms = DurW'(ms);
    return n;
  endfunction

  // Entries past a tune's length read as zero.
  function automatic note_t tune_note(input tune_e t, input logic [NoteIdxW-1:0] idx);
    note_t n;
    n = '0;
    case (t)
      TuneStartup: begin
        case (idx)
          3'd0:    n = mk_note(659, 300);
          3'd1:    n = mk_note(659, 300);
          3'd2:    n = mk_note(523, 100);
          3'd3:    n = mk_note(659, 300);
          3'd4:    n = mk_note(783, 550);
          3'd5:    n = mk_note(392, 575);
          default: n = '0;
        endcase
      end
      TuneFailed: begin
        case (idx)
          3'd0:    n = mk_note(480, 200);
          3'd1:    n = mk_note(400, 200);
          default: n = '0;
        endcase
      end
      TuneNoModule: begin
        case (idx)
          3'd0:    n = mk_note(676, 300);
          3'd1:    n = mk_note(520, 150);
          default: n = '0;
        endcase
      end
      default: begin
        case (idx)
          3'd0:    n = mk_note(520, 150);
          3'd1:    n = mk_note(676, 300);
          3'd2:    n = mk_note(0, 1000);
          default: n = '0;
        endcase
      end
    endcase
    return n;
  endfunction

endpackage

/* sv/bts_intf.sv */
// Handshake channel interfaces: input items, result items, configuration writes.
interface bts_in_if import bts_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [2:0] conn_state;

  modport source (output valid, output func, output conn_state, input ready);
  modport sink   (input valid, input func, input conn_state, output ready);
endinterface

interface bts_out_if import bts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       reply;
  logic [DurW-1:0]  wait_ms;
  logic             tone_on;
  logic [FreqW-1:0] tone_hz;
  logic [DurW-1:0]  tone_ms;
  logic             pin_drive;

  modport source (output valid, output reply, output wait_ms, output tone_on,
                  output tone_hz, output tone_ms, output pin_drive, input ready);
  modport sink   (input valid, input reply, input wait_ms, input tone_on,
                  input tone_hz, input tone_ms, input pin_drive, output ready);
endinterface

interface bts_cfg_if import bts_pkg::*; ();
  logic valid;
  logic ready;
  logic startup_beep_enable;

  modport source (output valid, output startup_beep_enable, input ready);
  modport sink   (input valid, input startup_beep_enable, output ready);
endinterface

/* sv/buzzer_tune_sequencer.sv */
// Buzzer tune sequencer top level: input stage, tune state machine, result stage.
//
//  channel | dir | payload                                            | transfer when
//  in_i    | in  | func, conn_state                                   | valid & ready
//  out_o   | out | reply, wait_ms, tone_on, tone_hz, tone_ms, pin_drive | valid & ready
//  cfg_i   | in  | startup_beep_enable                                | valid & ready
//
// Two register stages: an item is captured in the input register, processed
// combinationally against the tune state, and lands in the result register.
// One item per cycle is sustained while out_o is not stalled, the limit being
// the single state update per cycle. Reset
// (rst_ni low, async) idles the block with the startup tune selected and
// beeps enabled. A stalled output holds its result and the input register
// backs up behind it; cfg_i is always ready.
module buzzer_tune_sequencer import bts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bts_in_if.sink     in_i,
  bts_out_if.source  out_o,
  bts_cfg_if.sink    cfg_i
);

  // configuration
  logic beep_en_q;

  // input stage
  logic                in_vld_q;
  logic [1:0]          func_q;
  logic [2:0]          cs_q;

  // tune state
  logic [NoteIdxW-1:0] idx_q, idx_d;
  tune_e               sel_q, sel_d;
  logic                done_q, done_d;
  logic                pend_q, pend_d;
  logic [2:0]          last_q, last_d;
  logic                pin_q, pin_d;

  // result stage
  logic                out_vld_q;
  result_t             res_q, res_d;

  logic                adv;

  assign adv        = !out_vld_q || out_o.ready;
  assign in_i.ready = !in_vld_q || adv;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beep_en_q <= 1'b1;
    end else if (cfg_i.valid) begin
      beep_en_q <= cfg_i.startup_beep_enable;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      func_q <= in_i.func;
      cs_q   <= in_i.conn_state;
    end
  end

  // Link state to tune mapping; connect/disconnect only with beeps enabled.
  logic  map_hit;
  tune_e map_tune;

  always_comb begin
    map_hit  = 1'b0;
    map_tune = TuneLink;
    if (cs_q == LinkRadioFailed) begin
      map_hit  = 1'b1;
      map_tune = TuneFailed;
    end else if (cs_q == LinkNoModule) begin
      map_hit  = 1'b1;
      map_tune = TuneNoModule;
    end else if ((cs_q == LinkConnected || cs_q == LinkDisconnected) && beep_en_q) begin
      map_hit  = 1'b1;
      map_tune = TuneLink;
    end
  end

  // Tune engine. A fresh tune always plays its first note right away.
  logic  play_end;
  note_t cur_note;
  logic  do_start;
  tune_e start_t;
  note_t first_note;
  note_t emit;
  logic  do_emit;

  assign play_end   = idx_q >= tune_len(sel_q);
  assign cur_note   = tune_note(sel_q, idx_q);

  always_comb begin
    idx_d    = idx_q;
    sel_d    = sel_q;
    done_d   = done_q;
    pend_d   = pend_q;
    last_d   = last_q;
    pin_d    = pin_q;
    do_start = 1'b0;
    do_emit  = 1'b0;
    start_t  = TuneStartup;
    res_d    = '0;
    res_d.reply = ReplyIgnore;

    case (func_q)
      FuncStart: begin
        if (beep_en_q) begin
          do_start = 1'b1;
        end else begin
          res_d.reply = ReplyNever;
        end
      end
      FuncLink: begin
        if (idx_q == '0) begin
          if (cs_q != last_q) begin
            last_d = cs_q;
            if (map_hit) begin
              do_start = 1'b1;
              start_t  = map_tune;
            end else begin
              res_d.reply = ReplyNever;
            end
          end else begin
            res_d.reply = ReplyNever;
          end
        end else begin
          // mid-tune: only deferred until the first tune has ended, else ignored
          if (!done_q) pend_d = 1'b1;
        end
      end
      FuncTimer: begin
        if (play_end) begin
          pin_d       = 1'b0;
          idx_d       = '0;
          res_d.reply = ReplyNever;
          if (!done_q) begin
            done_d = 1'b1;
            if (pend_q) begin
              pend_d = 1'b0;
              if (map_hit) begin
                do_start = 1'b1;
                start_t  = map_tune;
              end
            end
          end
        end else begin
          do_emit = 1'b1;
          idx_d   = idx_q + NoteIdxW'(1);
        end
      end
      default: ;
    endcase

    if (do_start) begin
      sel_d   = start_t;
      pin_d   = 1'b1;
      idx_d   = NoteIdxW'(1);
      do_emit = 1'b1;
    end

    first_note = tune_note(start_t, '0);
    emit = do_start ? first_note : cur_note;
    if (do_emit) begin
      res_d.reply   = ReplyWait;
      res_d.wait_ms = emit.ms;
      if (emit.hz != '0) begin
        res_d.tone_on = 1'b1;
        res_d.tone_hz = emit.hz;
        res_d.tone_ms = emit.ms;
      end
    end
    res_d.pin_drive = pin_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      sel_q  <= TuneStartup;
      done_q <= 1'b0;
      pend_q <= 1'b0;
      last_q <= LinkNoneSeen;
      pin_q  <= 1'b0;
    end else if (in_vld_q && adv) begin
      idx_q  <= idx_d;
      sel_q  <= sel_d;
      done_q <= done_d;
      pend_q <= pend_d;
      last_q <= last_d;
      pin_q  <= pin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.reply     = res_q.reply;
  assign out_o.wait_ms   = res_q.wait_ms;
  assign out_o.tone_on   = res_q.tone_on;
  assign out_o.tone_hz   = res_q.tone_hz;
  assign out_o.tone_ms   = res_q.tone_ms;
  assign out_o.pin_drive = res_q.pin_drive;

endmodule

/* sv/bts_checker.sv */
// Port-level checks for the buzzer tune sequencer, bound to the top level.
module bts_checker import bts_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       reply,
  input logic [DurW-1:0]  wait_ms,
  input logic             tone_on,
  input logic [FreqW-1:0] tone_hz,
  input logic [DurW-1:0]  tone_ms,
  input logic             pin_drive
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(reply) && $stable(wait_ms)
      && $stable(tone_on) && $stable(tone_hz) && $stable(pin_drive))
    else $error("result changed while stalled");

  a_wait_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && reply != ReplyWait |-> wait_ms == '0 && !tone_on)
    else $error("wait time or tone without a wait reply");

  // an idle replay sounds with the pin left released, so no pin check here
  a_tone_pin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && tone_on |-> tone_hz != '0 && tone_ms == wait_ms)
    else $error("tone inconsistent with duration");

  a_silence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !tone_on |-> tone_hz == '0 && tone_ms == '0)
    else $error("tone fields set during silence");

endmodule

bind buzzer_tune_sequencer bts_checker u_bts_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .reply     (out_o.reply),
  .wait_ms   (out_o.wait_ms),
  .tone_on   (out_o.tone_on),
  .tone_hz   (out_o.tone_hz),
  .tone_ms   (out_o.tone_ms),
  .pin_drive (out_o.pin_drive)
);
